// ===== sv/fdzt_pkg.sv =====
// Package for the frame difference zone trigger.
// Holds register indexes, reset values, action codes and field widths.
// No dependencies.
package fdzt_pkg;

  // Default frame store size
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 512;

  // Register widths
  localparam int unsigned FW_W  = 11;
  localparam int unsigned FH_W  = 10;
  localparam int unsigned ZX_W  = 10;
  localparam int unsigned ZY_W  = 9;
  localparam int unsigned THR_W = 8;
  localparam int unsigned CNT_W = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Pixel and result word widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Register reset values
  localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = FW_W'(640);
  localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT = FH_W'(480);
  localparam logic [ZX_W-1:0]  RST_ZONE_X_FIRST = ZX_W'(213);
  localparam logic [ZX_W-1:0]  RST_ZONE_X_SECOND = ZX_W'(426);
  localparam logic [ZY_W-1:0]  RST_ZONE_Y_MIDDLE = ZY_W'(240);
  localparam logic [THR_W-1:0] RST_THRESHOLD    = THR_W'(128);
  localparam logic [CNT_W-1:0] RST_MOTION_LEVEL = CNT_W'(80);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_ZONE_X_FIRST  = 3'd2,
    REG_ZONE_X_SECOND = 3'd3,
    REG_ZONE_Y_MIDDLE = 3'd4,
    REG_THRESHOLD     = 3'd5,
    REG_MOTION_LEVEL  = 3'd6
  } cfg_reg_e;

  // Frame end decision
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SHOW = 2'd1,
    ACT_HIDE = 2'd2,
    ACT_QUIT = 2'd3
  } action_e;

endpackage

// ===== sv/fdzt_ram.sv =====
// Generic single-port RAM with registered, read-first output.
// Used as the previous-frame store. No dependencies.
module fdzt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Old contents come out when the same address is written
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem_q[addr_i];
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/frame_difference_zone_trigger.sv =====
// Frame difference zone trigger: top level.
// An accepted input word passes the stage 1 register and then the result word register.
// Throughput: one pixel per cycle while the result stream is not stalled; each
// pixel does one read and one write of the single-port frame store in its accept cycle.
// Reset: registers to defaults, position, counts and flags cleared; frame
// store contents undefined, no clearing pass. Uses fdzt_pkg and fdzt_ram.
module frame_difference_zone_trigger #(
  parameter int unsigned MAX_WIDTH  = fdzt_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = fdzt_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration writes
  input  logic                                cfg_we_i,
  input  logic [fdzt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fdzt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Pixel stream in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fdzt_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [7:0] gray_pixel
  // Result stream out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] pixel_difference, [9:8] action, [10] picture_shown,
  // [30:11] zone_a_count, [50:31] zone_b_count, [70:51] zone_c_count, [71] zero
  output logic [fdzt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast   // frame_done
);

  import fdzt_pkg::*;

  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned DEPTH = MAX_HEIGHT * (2 ** XW);
  localparam int unsigned AW    = $clog2(DEPTH);
  // Compare widths
  localparam int unsigned WCW = (XW + 1 > FW_W) ? XW + 1 : FW_W;
  localparam int unsigned HCW = (YW + 1 > FH_W) ? YW + 1 : FH_W;
  localparam int unsigned XCW = (XW > ZX_W) ? XW : ZX_W;
  localparam int unsigned YCW = (YW > ZY_W) ? YW : ZY_W;

  // Configuration registers
  logic [FW_W-1:0]  frame_width_q;
  logic [FH_W-1:0]  frame_height_q;
  logic [ZX_W-1:0]  zone_x_first_q;
  logic [ZX_W-1:0]  zone_x_second_q;
  logic [ZY_W-1:0]  zone_y_middle_q;
  logic [THR_W-1:0] threshold_q;
  logic [CNT_W-1:0] motion_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= RST_FRAME_WIDTH;
      frame_height_q  <= RST_FRAME_HEIGHT;
      zone_x_first_q  <= RST_ZONE_X_FIRST;
      zone_x_second_q <= RST_ZONE_X_SECOND;
      zone_y_middle_q <= RST_ZONE_Y_MIDDLE;
      threshold_q     <= RST_THRESHOLD;
      motion_level_q  <= RST_MOTION_LEVEL;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i[FH_W-1:0];
        REG_ZONE_X_FIRST:  zone_x_first_q  <= cfg_data_i[ZX_W-1:0];
        REG_ZONE_X_SECOND: zone_x_second_q <= cfg_data_i[ZX_W-1:0];
        REG_ZONE_Y_MIDDLE: zone_y_middle_q <= cfg_data_i[ZY_W-1:0];
        REG_THRESHOLD:     threshold_q     <= cfg_data_i[THR_W-1:0];
        REG_MOTION_LEVEL:  motion_level_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake between stages
  logic s1_valid_q;
  logic m_valid_q;
  logic s1_adv;
  logic in_acc;

  assign s1_adv        = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Raster position and end-of-line / end-of-frame detection
  logic [XW-1:0]  col_q, col_d;
  logic [YW-1:0]  row_q, row_d;
  logic [WCW-1:0] w_eff;
  logic [HCW-1:0] h_eff;
  logic [XW:0]    col_inc;
  logic [YW:0]    row_inc;
  logic           line_end;
  logic           frame_end;

  always_comb begin
    // Clamp frame size to 1..max
    if (frame_width_q == '0) begin
      w_eff = WCW'(1);
    end else if (WCW'(frame_width_q) > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h_eff = HCW'(1);
    end else if (HCW'(frame_height_q) > HCW'(MAX_HEIGHT)) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = HCW'(frame_height_q);
    end
    col_inc   = {1'b0, col_q} + 1'b1;
    row_inc   = {1'b0, row_q} + 1'b1;
    line_end  = WCW'(col_inc) >= w_eff;
    frame_end = line_end && (HCW'(row_inc) >= h_eff);
    if (frame_end) begin
      col_d = '0;
      row_d = '0;
    end else if (line_end) begin
      col_d = '0;
      row_d = row_inc[YW-1:0];
    end else begin
      col_d = col_inc[XW-1:0];
      row_d = row_q;
    end
  end

  // Frame store: read the old pixel and write the new one in the accept cycle
  logic [PIX_W-1:0] old_pix;

  fdzt_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (in_acc),
    .we_i    (in_acc),
    .addr_i  (AW'({row_q, col_q})),
    .wdata_i (s_axis_tdata[PIX_W-1:0]),
    .rdata_o (old_pix)
  );

  // Stage 1 payload
  logic [PIX_W-1:0] s1_pix_q;
  logic [XW-1:0]    s1_x_q;
  logic [YW-1:0]    s1_y_q;
  logic             s1_last_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q  <= s_axis_tdata[PIX_W-1:0];
      s1_x_q    <= col_q;
      s1_y_q    <= row_q;
      s1_last_q <= frame_end;
    end
  end

  // Frame state
  logic [CNT_W-1:0] cnt_a_q, cnt_b_q, cnt_c_q;
  logic             have_prev_q;
  logic             shown_q;
  logic             stopped_q;

  // Difference, zone counting and frame end decision
  logic [PIX_W-1:0] diff;
  logic             changed;
  logic [XCW-1:0]   x_ext, x1_ext, x2_ext;
  logic [YCW-1:0]   y_ext, ym_ext;
  logic             in_a, in_b, in_c;
  logic [CNT_W-1:0] cnt_a_n, cnt_b_n, cnt_c_n;
  action_e          act_n;
  logic             shown_n;
  logic             stopped_n;

  always_comb begin
    if (!have_prev_q) begin
      diff = '0;
    end else if (s1_pix_q >= old_pix) begin
      diff = s1_pix_q - old_pix;
    end else begin
      diff = old_pix - s1_pix_q;
    end
    changed = have_prev_q && (diff >= threshold_q);

    x_ext  = XCW'(s1_x_q);
    x1_ext = XCW'(zone_x_first_q);
    x2_ext = XCW'(zone_x_second_q);
    y_ext  = YCW'(s1_y_q);
    ym_ext = YCW'(zone_y_middle_q);

    // Zones in priority A, B, C
    in_a = (x_ext < x1_ext) && (y_ext < ym_ext);
    in_b = !in_a && (x_ext > x1_ext) && (x_ext < x2_ext) && (y_ext > ym_ext);
    in_c = !in_a && !in_b && (x_ext > x2_ext) && (y_ext < ym_ext);

    cnt_a_n = cnt_a_q;
    cnt_b_n = cnt_b_q;
    cnt_c_n = cnt_c_q;
    if (changed && in_a && cnt_a_q != COUNT_MAX) cnt_a_n = cnt_a_q + 1'b1;
    if (changed && in_b && cnt_b_q != COUNT_MAX) cnt_b_n = cnt_b_q + 1'b1;
    if (changed && in_c && cnt_c_q != COUNT_MAX) cnt_c_n = cnt_c_q + 1'b1;

    act_n     = ACT_NONE;
    shown_n   = shown_q;
    stopped_n = stopped_q;
    if (s1_last_q && have_prev_q && !stopped_q) begin
      if (cnt_a_n > motion_level_q && !shown_q) begin
        act_n   = ACT_SHOW;
        shown_n = 1'b1;
      end else if (cnt_c_n > motion_level_q && shown_q) begin
        act_n   = ACT_HIDE;
        shown_n = 1'b0;
      end else if (cnt_b_n > motion_level_q) begin
        act_n     = ACT_QUIT;
        stopped_n = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      m_valid_q   <= 1'b0;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      cnt_c_q     <= '0;
      have_prev_q <= 1'b0;
      shown_q     <= 1'b0;
      stopped_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        shown_q   <= shown_n;
        stopped_q <= stopped_n;
        if (s1_last_q) begin
          cnt_a_q     <= '0;
          cnt_b_q     <= '0;
          cnt_c_q     <= '0;
          have_prev_q <= 1'b1;
        end else begin
          cnt_a_q <= cnt_a_n;
          cnt_b_q <= cnt_b_n;
          cnt_c_q <= cnt_c_n;
        end
      end
    end
  end

  // Result word register
  logic [PIX_W-1:0] out_diff_q;
  action_e          out_act_q;
  logic             out_shown_q;
  logic [CNT_W-1:0] out_a_q, out_b_q, out_c_q;
  logic             out_last_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_diff_q  <= diff;
      out_act_q   <= act_n;
      out_shown_q <= shown_n;
      out_a_q     <= cnt_a_n;
      out_b_q     <= cnt_b_n;
      out_c_q     <= cnt_c_n;
      out_last_q  <= s1_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, out_c_q, out_b_q, out_a_q, out_shown_q,
                          out_act_q, out_diff_q};

endmodule
